>>> rtl/rbil_pkg.sv
// shared types and constants for the ring buffer indexed list
package rbil_pkg;

    // storage geometry
    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // fixed field widths of the stream beats
    localparam int OP_W    = 3;
    localparam int POS_W   = 7;
    localparam int ELEM_W  = 32;
    localparam int STAT_W  = 2;
    localparam int ECNT_W  = 7;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PREPEND   = 3'd0,
        OP_APPEND    = 3'd1,
        OP_REM_FIRST = 3'd2,
        OP_REM_LAST  = 3'd3,
        OP_SET       = 3'd4,
        OP_GET       = 3'd5,
        OP_INSERT    = 3'd6,
        OP_REM_AT    = 3'd7
    } t_op;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // what every cell does at launch
    typedef enum logic [1:0] {
        M_HOLD   = 2'd0,
        M_WRITE  = 2'd1,
        M_INSERT = 2'd2,
        M_DELETE = 2'd3
    } t_mode;

    // controller sequencing
    typedef enum logic {
        S_IDLE  = 1'b0,
        S_SHIFT = 1'b1
    } t_state;

    // control broadcast from the controller to all cells
    typedef struct packed {
        logic              launch;
        t_mode             mode;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] word;
        logic              shift;
    } t_cell_ctl;

endpackage

>>> rtl/ring_buffer_indexed_list.sv
// top level of the ring buffer indexed list: controller and row of cells
//
// An ordered list of up to 64 words held in a row of cells, cell k holding
// list entry k, so the ring's head pointer is implicit. Every operation edits
// the row when it is accepted: end and indexed inserts and removes move all later
// cells by one neighbor at once. The word read or removed is snapshot into
// the read chain and walks one cell per cycle toward cell 0; an item's result
// waits on that walk, which grows with the index of the entry it reads, and
// then on a free output register. The next item is accepted once the previous
// result sits in the output register, even if not yet taken.
module ring_buffer_indexed_list (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // operation [2:0], position [9:3], element_in [41:10], zero [47:42]
    input  logic [rbil_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // element_out [31:0], status [33:32], entry_count [40:34], zero [47:41]
    output logic [rbil_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    // input fields
    rbil_pkg::t_op                 w_op;
    logic [rbil_pkg::POS_W-1:0]    w_pos;
    logic [rbil_pkg::ELEM_W-1:0]   w_elem;

    assign w_op   = rbil_pkg::t_op'(i_s_tdata[2:0]);
    assign w_pos  = i_s_tdata[9:3];
    assign w_elem = i_s_tdata[41:10];

    // control state
    rbil_pkg::t_state               r_state, n_state;
    logic [rbil_pkg::CNT_W-1:0]     r_count;
    logic [rbil_pkg::IDX_W-1:0]     r_steps;
    logic                           r_rd_en;
    rbil_pkg::t_status              r_st;
    logic                           r_out_valid;
    logic [rbil_pkg::ELEM_W-1:0]    r_out_elem;
    rbil_pkg::t_status              r_out_st;
    logic [rbil_pkg::ECNT_W-1:0]    r_out_cnt;

    // decode results
    rbil_pkg::t_mode                w_mode;
    logic [rbil_pkg::IDX_W-1:0]     w_idx;
    logic [rbil_pkg::IDX_W-1:0]     w_rd_idx;
    logic                           w_rd_en;
    rbil_pkg::t_status              w_st;
    logic [rbil_pkg::CNT_W-1:0]     n_count;

    logic                           w_accept;
    logic                           w_done;
    logic                           w_full;
    logic                           w_empty;
    logic [rbil_pkg::CMP_W-1:0]     w_posx;
    logic [rbil_pkg::CMP_W-1:0]     w_cntx;
    logic [rbil_pkg::IDX_W-1:0]     w_pos_idx;
    logic [rbil_pkg::IDX_W-1:0]     w_cnt_idx;

    rbil_pkg::t_cell_ctl            w_ctl;
    logic [rbil_pkg::DATA_W-1:0]    w_data  [rbil_pkg::DEPTH];
    logic [rbil_pkg::DATA_W-1:0]    w_carry [rbil_pkg::DEPTH];

    assign w_full    = (r_count == rbil_pkg::CNT_W'(rbil_pkg::DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_posx    = rbil_pkg::CMP_W'(w_pos);
    assign w_cntx    = rbil_pkg::CMP_W'(r_count);
    assign w_pos_idx = w_posx[rbil_pkg::IDX_W-1:0];
    assign w_cnt_idx = w_cntx[rbil_pkg::IDX_W-1:0];

    // operation decode against the current count
    always_comb begin
        w_mode   = rbil_pkg::M_HOLD;
        w_idx    = '0;
        w_rd_idx = '0;
        w_rd_en  = 1'b0;
        w_st     = rbil_pkg::ST_OK;
        n_count  = r_count;
        unique case (w_op)
            rbil_pkg::OP_PREPEND: begin
                if (w_full) begin
                    w_st = rbil_pkg::ST_FULL;
                end else begin
                    w_mode  = rbil_pkg::M_INSERT;
                    n_count = r_count + rbil_pkg::CNT_W'(1);
                end
            end
            rbil_pkg::OP_APPEND: begin
                if (w_full) begin
                    w_st = rbil_pkg::ST_FULL;
                end else begin
                    w_mode  = rbil_pkg::M_WRITE;
                    w_idx   = w_cnt_idx;
                    n_count = r_count + rbil_pkg::CNT_W'(1);
                end
            end
            rbil_pkg::OP_REM_FIRST: begin
                if (w_empty) begin
                    w_st = rbil_pkg::ST_RANGE;
                end else begin
                    w_mode  = rbil_pkg::M_DELETE;
                    w_rd_en = 1'b1;
                    n_count = r_count - rbil_pkg::CNT_W'(1);
                end
            end
            rbil_pkg::OP_REM_LAST: begin
                if (w_empty) begin
                    w_st = rbil_pkg::ST_RANGE;
                end else begin
                    w_rd_en  = 1'b1;
                    w_rd_idx = w_cnt_idx - rbil_pkg::IDX_W'(1);
                    n_count  = r_count - rbil_pkg::CNT_W'(1);
                end
            end
            rbil_pkg::OP_SET: begin
                if (w_posx < w_cntx) begin
                    w_mode = rbil_pkg::M_WRITE;
                    w_idx  = w_pos_idx;
                end else if (w_full) begin
                    w_st = rbil_pkg::ST_FULL;
                end else begin
                    w_mode  = rbil_pkg::M_WRITE;
                    w_idx   = w_cnt_idx;
                    n_count = r_count + rbil_pkg::CNT_W'(1);
                end
            end
            rbil_pkg::OP_GET: begin
                if (w_posx < w_cntx) begin
                    w_rd_en  = 1'b1;
                    w_rd_idx = w_pos_idx;
                end else begin
                    w_st = rbil_pkg::ST_RANGE;
                end
            end
            rbil_pkg::OP_INSERT: begin
                if (w_full) begin
                    w_st = rbil_pkg::ST_FULL;
                end else begin
                    w_mode  = rbil_pkg::M_INSERT;
                    w_idx   = (w_posx > w_cntx) ? w_cnt_idx : w_pos_idx;
                    n_count = r_count + rbil_pkg::CNT_W'(1);
                end
            end
            rbil_pkg::OP_REM_AT: begin
                if (w_posx >= w_cntx) begin
                    w_st = rbil_pkg::ST_RANGE;
                end else begin
                    w_mode   = rbil_pkg::M_DELETE;
                    w_idx    = w_pos_idx;
                    w_rd_en  = 1'b1;
                    w_rd_idx = w_pos_idx;
                    n_count  = r_count - rbil_pkg::CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // handshake terms
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_done   = (r_state == rbil_pkg::S_SHIFT) && (r_steps == '0)
                      && (!r_out_valid || i_m_tready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rbil_pkg::S_IDLE:  if (w_accept) n_state = rbil_pkg::S_SHIFT;
            rbil_pkg::S_SHIFT: if (w_done)   n_state = rbil_pkg::S_IDLE;
            default:           n_state = rbil_pkg::S_IDLE;
        endcase
    end

    // state outputs: input ready and cell control
    always_comb begin
        o_s_tready  = 1'b0;
        w_ctl       = '0;
        w_ctl.word  = rbil_pkg::DATA_W'(w_elem);
        w_ctl.mode  = w_mode;
        w_ctl.idx   = w_idx;
        unique case (r_state)
            rbil_pkg::S_IDLE: begin
                o_s_tready   = 1'b1;
                w_ctl.launch = i_s_tvalid;
            end
            rbil_pkg::S_SHIFT: begin
                w_ctl.shift = (r_steps != '0);
            end
            default: ;
        endcase
    end

    // controller registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbil_pkg::S_IDLE;
            r_count     <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_count <= n_count;
                r_steps <= w_rd_idx;
            end else if (r_state == rbil_pkg::S_SHIFT && r_steps != '0) begin
                r_steps <= r_steps - rbil_pkg::IDX_W'(1);
            end
            if (w_done)          r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
        end
    end

    // per item result fields, held while the read chain walks
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_en <= w_rd_en;
            r_st    <= w_st;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_elem <= r_rd_en ? rbil_pkg::ELEM_W'(w_carry[0]) : '0;
            r_out_st   <= r_st;
            r_out_cnt  <= rbil_pkg::ECNT_W'(r_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(rbil_pkg::OUT_TDATA_W - 41){1'b0}},
                         r_out_cnt, r_out_st, r_out_elem};

    // row of cells
    for (genvar g = 0; g < rbil_pkg::DEPTH; g++) begin : g_cell
        logic [rbil_pkg::DATA_W-1:0] w_left;
        logic [rbil_pkg::DATA_W-1:0] w_right;
        logic [rbil_pkg::DATA_W-1:0] w_rcarry;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == rbil_pkg::DEPTH - 1) begin : g_last
            assign w_right  = w_data[g];
            assign w_rcarry = '0;
        end else begin : g_mid_r
            assign w_right  = w_data[g+1];
            assign w_rcarry = w_carry[g+1];
        end

        rbil_cell u_cell (
            .i_clk         (i_clk),
            .i_cell_idx    (rbil_pkg::IDX_W'(g)),
            .i_ctl         (w_ctl),
            .i_left_data   (w_left),
            .i_right_data  (w_right),
            .i_right_carry (w_rcarry),
            .o_data        (w_data[g]),
            .o_carry       (w_carry[g])
        );
    end

    // entry count stays within capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rbil_pkg::CNT_W'(rbil_pkg::DEPTH))
        else $error("entry count beyond capacity");

    // an accepted beat always starts the read walk
    a_accept_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == rbil_pkg::S_SHIFT) && (r_steps == $past(w_rd_idx)))
        else $error("accepted beat did not start the read walk");

    // the walk counts down one cell per cycle
    a_walk_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rbil_pkg::S_SHIFT) && (r_steps != '0)
        |=> (r_steps == $past(r_steps) - rbil_pkg::IDX_W'(1)))
        else $error("read walk skipped a cell");

    // a result appears only at the end of a walk
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == rbil_pkg::S_SHIFT)
        else $error("result without a finished walk");

endmodule

>>> rtl/rbil_cell.sv
// one list cell: holds list entry at its index and one stage of the read chain
module rbil_cell (
    input  logic                          i_clk,
    input  logic [rbil_pkg::IDX_W-1:0]    i_cell_idx,
    input  rbil_pkg::t_cell_ctl           i_ctl,
    input  logic [rbil_pkg::DATA_W-1:0]   i_left_data,
    input  logic [rbil_pkg::DATA_W-1:0]   i_right_data,
    input  logic [rbil_pkg::DATA_W-1:0]   i_right_carry,
    output logic [rbil_pkg::DATA_W-1:0]   o_data,
    output logic [rbil_pkg::DATA_W-1:0]   o_carry
);

    logic [rbil_pkg::DATA_W-1:0] r_data;
    logic [rbil_pkg::DATA_W-1:0] r_carry;

    // entry update: write in place, take from lower neighbor, or from upper neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.launch) begin
            unique case (i_ctl.mode)
                rbil_pkg::M_WRITE: begin
                    if (i_cell_idx == i_ctl.idx) r_data <= i_ctl.word;
                end
                rbil_pkg::M_INSERT: begin
                    if (i_cell_idx == i_ctl.idx)     r_data <= i_ctl.word;
                    else if (i_cell_idx > i_ctl.idx) r_data <= i_left_data;
                end
                rbil_pkg::M_DELETE: begin
                    if (i_cell_idx >= i_ctl.idx) r_data <= i_right_data;
                end
                default: ;
            endcase
        end
    end

    // read chain: snapshot old entry at launch, then move one cell toward cell 0
    always_ff @(posedge i_clk) begin
        if (i_ctl.launch) begin
            r_carry <= r_data;
        end else if (i_ctl.shift) begin
            r_carry <= i_right_carry;
        end
    end

    assign o_data  = r_data;
    assign o_carry = r_carry;

endmodule

>>> tb/ring_buffer_indexed_list_test.sv
// self-checking stream testbench for the ring buffer indexed list
module ring_buffer_indexed_list_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rbil_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_ITEMS  = 1680;

    // one command beat and one result beat
    typedef struct packed {
        t_op               op;
        logic [POS_W-1:0]  pos;
        logic [ELEM_W-1:0] word;
    } list_cmd_t;

    typedef struct packed {
        logic [ELEM_W-1:0] word;
        t_status           status;
        logic [ECNT_W-1:0] count;
    } list_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    ring_buffer_indexed_list DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow list, entry 0 at the front
    logic [ELEM_W-1:0] list_words[$];
    list_cmd_t         pending_cmds[$];
    list_result_t      expected_results[$];

    int n_errors = 0;
    int n_accepted = 0;
    int n_results = 0;

    // sender state
    list_cmd_t cur_cmd = '0;
    logic      offering = 1'b0;
    logic      tx_steady = 1'b0;
    logic      tx_drain = 1'b0;
    int        tx_gap = 0;

    // receiver state
    logic rx_steady = 1'b0;
    logic hold_done = 1'b0;
    int   rx_stall = 0;

    int idle_cycles = 0;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // apply one command to the shadow list and queue the beat it should return
    function automatic void apply_list_op(list_cmd_t cmd);
        list_result_t res;
        int           p;
        res = '{word: '0, status: ST_OK, count: '0};
        p = int'(cmd.pos);
        case (cmd.op)
            OP_PREPEND: begin
                if (list_words.size() >= DEPTH) res.status = ST_FULL;
                else list_words.push_front(cmd.word);
            end
            OP_APPEND: begin
                if (list_words.size() >= DEPTH) res.status = ST_FULL;
                else list_words.push_back(cmd.word);
            end
            OP_REM_FIRST: begin
                if (list_words.size() == 0) res.status = ST_RANGE;
                else res.word = list_words.pop_front();
            end
            OP_REM_LAST: begin
                if (list_words.size() == 0) res.status = ST_RANGE;
                else res.word = list_words.pop_back();
            end
            OP_SET: begin
                // writing past the end appends
                if (p < list_words.size()) list_words[p] = cmd.word;
                else if (list_words.size() >= DEPTH) res.status = ST_FULL;
                else list_words.push_back(cmd.word);
            end
            OP_GET: begin
                if (p < list_words.size()) res.word = list_words[p];
                else res.status = ST_RANGE;
            end
            OP_INSERT: begin
                // inserting past the end appends
                if (list_words.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    if (p > list_words.size()) p = list_words.size();
                    list_words.insert(p, cmd.word);
                end
            end
            default: begin
                if (p >= list_words.size()) begin
                    res.status = ST_RANGE;
                end else begin
                    res.word = list_words[p];
                    list_words.delete(p);
                end
            end
        endcase
        res.count = ECNT_W'(list_words.size());
        expected_results.push_back(res);
    endfunction

    function automatic void queue_cmd(t_op op, logic [POS_W-1:0] pos, logic [ELEM_W-1:0] word);
        list_cmd_t cmd;
        cmd.op = op;
        cmd.pos = pos;
        cmd.word = word;
        pending_cmds.push_back(cmd);
    endfunction

    // index biased toward live entries, with the end and out-of-range too
    function automatic logic [POS_W-1:0] pick_pos(int sz);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70 && sz > 0) return POS_W'($urandom_range(0, sz - 1));
        if (r < 85) return POS_W'(sz + $urandom_range(0, 1));
        return POS_W'($urandom_range(0, 127));
    endfunction

    // sender: presents queued commands with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (offering && o_s_tready) begin
                apply_list_op(cur_cmd);
                n_accepted++;
                offering = 1'b0;
                tx_gap = tx_steady ? 0 : pick_gap();
                if ($urandom_range(0, 149) == 0) tx_steady = !tx_steady;
                if (n_accepted % 500 == 0) tx_drain = 1'b1;
            end
            if (!offering) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (tx_drain) begin
                    // pause until every outstanding beat is back
                    if (expected_results.size() == 0) tx_drain = 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    offering = 1'b1;
                end
            end
            i_s_tvalid <= offering;
            i_s_tdata <= {6'b0, cur_cmd.word, cur_cmd.pos, cur_cmd.op};
        end
    end

    // receiver: checks result beats, stalls at random
    always @(posedge i_clk) begin
        list_result_t exp_res;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result beat %h", o_m_tdata);
                end else begin
                    exp_res = expected_results.pop_front();
                    if (o_m_tdata[31:0] !== exp_res.word
                            || o_m_tdata[33:32] !== exp_res.status
                            || o_m_tdata[40:34] !== exp_res.count
                            || o_m_tdata[47:41] !== '0) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("result %0d: word %h status %0d count %0d, expected %h %0d %0d",
                                     n_results, o_m_tdata[31:0], o_m_tdata[33:32],
                                     o_m_tdata[40:34], exp_res.word, exp_res.status,
                                     exp_res.count);
                    end
                end
            end
            // one long hold-off so the block backs up into its input
            if (!hold_done && n_results >= 700) begin
                rx_stall = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0) rx_stall = pick_gap();
                if ($urandom_range(0, 299) == 0) rx_steady = !rx_steady;
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        t_op               op;
        logic [ELEM_W-1:0] w;
        logic              growing;
        int                phase_left;
        int                r;

        growing = 1'b0;
        phase_left = 0;

        // removes and reads on an empty list
        queue_cmd(OP_REM_FIRST, 7'd0, 32'hDEAD_BEEF);
        queue_cmd(OP_REM_LAST, 7'd0, 32'h0);
        queue_cmd(OP_GET, 7'd0, 32'h0);
        queue_cmd(OP_REM_AT, 7'd0, 32'hFFFF_FFFF);
        // both ends, set in range and past the end, insert in range and past the end
        queue_cmd(OP_APPEND, 7'd0, 32'hFFFF_FFFF);
        queue_cmd(OP_PREPEND, 7'd127, 32'h0000_0000);
        queue_cmd(OP_SET, 7'd0, 32'hA5A5_A5A5);
        queue_cmd(OP_SET, 7'd127, 32'h5A5A_5A5A);
        queue_cmd(OP_INSERT, 7'd1, 32'h1234_5678);
        queue_cmd(OP_INSERT, 7'd127, 32'h8000_0001);
        queue_cmd(OP_INSERT, 7'd0, 32'h7FFF_FFFE);
        // reads at the last entry and just past it
        queue_cmd(OP_GET, 7'd5, 32'h0);
        queue_cmd(OP_GET, 7'd6, 32'h0);
        queue_cmd(OP_GET, 7'd64, 32'h0);
        queue_cmd(OP_GET, 7'd0, 32'h0);
        queue_cmd(OP_REM_AT, 7'd2, 32'h0);
        queue_cmd(OP_REM_AT, 7'd100, 32'h0);
        queue_cmd(OP_REM_AT, 7'd4, 32'h0);
        queue_cmd(OP_REM_LAST, 7'd0, 32'h0);
        queue_cmd(OP_REM_FIRST, 7'd0, 32'h0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // alternating grow and shrink phases that reach a full and an empty list
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (phase_left == 0) begin
                growing = !growing;
                phase_left = $urandom_range(120, 250);
            end
            phase_left--;
            while (pending_cmds.size() >= 2) @(posedge i_clk);
            r = $urandom_range(0, 99);
            if (r < 10) begin
                op = t_op'($urandom_range(0, 7));
            end else if (r < 80) begin
                if ((r < 65) == growing) begin
                    case ($urandom_range(0, 2))
                        0: op = OP_PREPEND;
                        1: op = OP_APPEND;
                        default: op = OP_INSERT;
                    endcase
                end else begin
                    case ($urandom_range(0, 2))
                        0: op = OP_REM_FIRST;
                        1: op = OP_REM_LAST;
                        default: op = OP_REM_AT;
                    endcase
                end
            end else begin
                op = (r < 90) ? OP_SET : OP_GET;
            end
            r = $urandom_range(0, 19);
            if (r == 0) w = '0;
            else if (r == 1) w = '1;
            else w = $urandom();
            queue_cmd(op, pick_pos(list_words.size()), w);
        end

        // drain
        while (pending_cmds.size() != 0 || offering) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/rbil_pkg.sv
rtl/rbil_cell.sv
rtl/ring_buffer_indexed_list.sv
tb/ring_buffer_indexed_list_test.sv
